/* hdl/assert_macros.svh */
// Assertion macros used by the checker of the radar blip renderer.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition in one cycle implies a consequence in the next cycle.
`define RBAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Check that a signal keeps its value into the next cycle while a condition holds.
`define RBAR_ASSERT_HOLD(label, clk, rst, cond, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

/* hdl/rbar_pkg.sv */
// Package for the radar blip renderer: register map, op codes, fixed-point
// constants, shared multiply unit request type and sequencer states. No dependencies.
`timescale 1ns / 1ps

package rbar_pkg;

   // Port widths
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 24;
   localparam int ReqDataW = 40;
   localparam int ReqUserW = 2;
   localparam int RspDataW = 8;

   // Item op codes carried on req_tuser
   localparam logic [ReqUserW-1:0] OP_CLEAR  = 2'd0;
   localparam logic [ReqUserW-1:0] OP_LOAD   = 2'd1;
   localparam logic [ReqUserW-1:0] OP_RENDER = 2'd2;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_MAP_SIZE    = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_PLAYER_X    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PLAYER_Y    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_FACING_COS  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_FACING_SIN  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_PIX_PER_BLK = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_RADIUS_SQ   = 3'd6;
   localparam logic [CsrIdxW-1:0] CSR_INV_RAD_SQ  = 3'd7;

   // Shared multiply-accumulate unit widths
   localparam int MacAW = 36;
   localparam int MacBW = 25;
   localparam int MacPW = MacAW + MacBW;
   localparam int AccW  = 54;

   // Blip coordinate width (signed Q12.8 pixels) and table entry width
   localparam int CoordW = 20;
   localparam int EntryW = 2 * CoordW;
   localparam int CentreW = 19;

   // Fixed-point constants
   localparam logic signed [AccW-1:0]   RangeSqQ16 = 54'sd8659204;
   localparam logic signed [AccW-1:0]   RoundBias  = 54'sd2097152;
   localparam logic signed [32:0]       CoordMax   = 33'sd524287;
   localparam logic signed [32:0]       CoordMin   = -33'sd524288;
   localparam logic [16:0]              OneQ16     = 17'h10000;

   // Configuration register set
   typedef struct packed {
      logic [10:0]        map_size;
      logic [15:0]        player_x;
      logic [15:0]        player_y;
      logic signed [15:0] facing_cos;
      logic signed [15:0] facing_sin;
      logic [15:0]        pix_per_blk;
      logic [17:0]        radius_sq;
      logic [23:0]        inv_radius_sq;
   } cfg_type;

   // Accumulator update modes
   typedef enum logic [1:0] {
      MAC_LOAD,
      MAC_ADD,
      MAC_SUB,
      MAC_BIAS
   } mac_mode_type;

   // Request from the sequencer to the shared unit
   typedef struct packed {
      logic                    en;
      mac_mode_type            mode;
      logic signed [MacAW-1:0] a;
      logic signed [MacBW-1:0] b;
   } mac_req_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_L_DX,
      S_L_DY,
      S_L_RANGE,
      S_L_RX1,
      S_L_PX,
      S_L_PXW,
      S_L_RY1,
      S_L_PY,
      S_L_WR,
      S_R_FETCH,
      S_R_DX,
      S_R_DY,
      S_R_TEST,
      S_R_TERM,
      S_R_OUT
   } seq_state_type;

endpackage

/* hdl/rbar_mac.sv */
// Shared signed multiply-accumulate unit of the radar blip renderer.
// Depends on rbar_pkg.
`timescale 1ns / 1ps

module rbar_mac
   import rbar_pkg::*;
(
   input  logic                   clock,
   input  mac_req_type            mac_req,
   output logic signed [AccW-1:0] acc
);

   logic signed [MacPW-1:0] prod;
   logic signed [AccW-1:0]  prod_t;
   logic signed [AccW-1:0]  acc_ff;
   logic signed [AccW-1:0]  acc_in;

   // Multiply the two operands
   assign prod   = $signed(mac_req.a) * $signed(mac_req.b);
   assign prod_t = prod[AccW-1:0];

   // Select the accumulator update
   always_comb begin
      case (mac_req.mode)
         MAC_LOAD: acc_in = prod_t;
         MAC_ADD:  acc_in = acc_ff + prod_t;
         MAC_SUB:  acc_in = acc_ff - prod_t;
         MAC_BIAS: acc_in = RoundBias + prod_t;
         default:  acc_in = prod_t;
      endcase
   end

   // Hold the accumulator unless a request is issued
   always_ff @(posedge clock) begin
      if (mac_req.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* hdl/rbar_blip_ram.sv */
// Blip position table: one write port, one registered read port.
// Depends on rbar_pkg for the entry width.
`timescale 1ns / 1ps

module rbar_blip_ram
   import rbar_pkg::*;
#(
   parameter int Depth = 64,
   parameter int AddrW = 6
)
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AddrW-1:0]  wr_addr,
   input  logic [EntryW-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AddrW-1:0]  rd_addr,
   output logic [EntryW-1:0] rd_data
);

   logic [EntryW-1:0] mem [Depth];
   logic [EntryW-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/rbar_seq.sv */
// Sequencer of the radar blip renderer: accepts words, steps the shared
// multiply unit through load and render work, keeps the blip count and result word.
// Depends on rbar_pkg; drives rbar_mac and rbar_blip_ram from the top level.
`timescale 1ns / 1ps

module rbar_seq
   import rbar_pkg::*;
#(
   parameter int MaxBlips = 64,
   parameter int CntW     = 7,
   parameter int IdxW     = 6
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ReqDataW-1:0]    req_tdata,
   input  logic [ReqUserW-1:0]    req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataW-1:0]    rsp_tdata,
   output mac_req_type            mac_req,
   input  logic signed [AccW-1:0] mac_acc,
   output logic                   ram_wr_en,
   output logic [IdxW-1:0]        ram_wr_addr,
   output logic [EntryW-1:0]      ram_wr_data,
   output logic                   ram_rd_en,
   output logic [IdxW-1:0]        ram_rd_addr,
   input  logic [EntryW-1:0]      ram_rd_data
);

   seq_state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] walk_ff, walk_in;
   logic [16:0]     sum_ff, sum_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] alpha_ff, alpha_in;
   logic signed [CoordW-1:0] pix_x_ff, pix_x_in;
   logic [7:0]      col_ff, row_ff;
   logic [9:0]      px_ff, py_ff;

   logic            accept;
   logic [CntW-1:0] walk_nx;
   logic signed [17:0] dx, dy;
   logic signed [20:0] ddx, ddy;
   logic signed [11:0] size_m1;
   logic signed [CentreW-1:0] centre;
   logic [25:0]     limit;
   logic            in_radius;
   logic [16:0]     frac;
   logic [16:0]     term;
   logic [17:0]     sum_wide;
   logic [24:0]     scaled;

   // Convert a rounded pixel product to a saturated coordinate
   function automatic logic signed [CoordW-1:0] to_coord(
      input logic signed [AccW-1:0]    prod,
      input logic signed [CentreW-1:0] ctr
   );
      logic signed [32:0] v;
      v = $signed({prod[AccW-1], prod[AccW-1:22]}) + 33'(ctr);
      if (v > CoordMax) begin
         to_coord = CoordMax[CoordW-1:0];
      end else if (v < CoordMin) begin
         to_coord = CoordMin[CoordW-1:0];
      end else begin
         to_coord = v[CoordW-1:0];
      end
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign walk_nx    = walk_ff + CntW'(1);

   // Target offset from the player in Q8.8 blocks
   assign dx = $signed({2'b00, col_ff, 8'h80}) - $signed({2'b00, cfg.player_x});
   assign dy = $signed({2'b00, row_ff, 8'h80}) - $signed({2'b00, cfg.player_y});

   // Pixel offset from the stored blip in Q12.8 pixels
   assign ddx = $signed({3'b000, px_ff, 8'h00})
              - $signed({ram_rd_data[CoordW-1], ram_rd_data[CoordW-1:0]});
   assign ddy = $signed({3'b000, py_ff, 8'h00})
              - $signed({ram_rd_data[EntryW-1], ram_rd_data[EntryW-1:CoordW]});

   // Minimap centre, (map_size - 1) * 128
   assign size_m1 = $signed({1'b0, cfg.map_size}) - 12'sd1;
   assign centre  = {size_m1, 7'b0000000};

   // Radius test and clamped blip term
   assign limit     = {cfg.radius_sq, 8'h00};
   assign in_radius = $unsigned(mac_acc) < {{(AccW-26){1'b0}}, limit};
   assign frac      = (mac_acc[AccW-2:16] > {{(AccW-34){1'b0}}, OneQ16}) ?
                      OneQ16 : mac_acc[32:16];
   assign term      = OneQ16 - frac;
   assign sum_wide  = {1'b0, sum_ff} + {1'b0, term};

   // Alpha = sum * 255 >> 16
   assign scaled = {sum_ff, 8'h00} - {8'h00, sum_ff};

   // Next state, shared unit requests and table access
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      sum_in       = sum_ff;
      pix_x_in     = pix_x_ff;
      alpha_in     = alpha_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mac_req      = '{en: 1'b0, mode: MAC_LOAD, a: '0, b: '0};
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[IdxW-1:0];
      ram_wr_data  = {to_coord(mac_acc, centre), pix_x_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = walk_ff[IdxW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_tuser)
                  OP_CLEAR: count_in = '0;
                  OP_LOAD: begin
                     if (!req_tdata[16] && (count_ff < CntW'(MaxBlips))) begin
                        state_in = S_L_DX;
                     end
                  end
                  OP_RENDER: begin
                     sum_in  = '0;
                     walk_in = '0;
                     state_in = (count_ff == '0) ? S_R_OUT : S_R_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         // Squared distance for the range test
         S_L_DX: begin
            mac_req  = '{en: 1'b1, mode: MAC_LOAD, a: MacAW'(dx), b: MacBW'(dx)};
            state_in = S_L_DY;
         end
         S_L_DY: begin
            mac_req  = '{en: 1'b1, mode: MAC_ADD, a: MacAW'(dy), b: MacBW'(dy)};
            state_in = S_L_RANGE;
         end
         // Drop far targets, else start rx = dx*cos + dy*sin
         S_L_RANGE: begin
            if (mac_acc > RangeSqQ16) begin
               state_in = S_IDLE;
            end else begin
               mac_req  = '{en: 1'b1, mode: MAC_LOAD, a: MacAW'(dx),
                            b: MacBW'(cfg.facing_cos)};
               state_in = S_L_RX1;
            end
         end
         S_L_RX1: begin
            mac_req  = '{en: 1'b1, mode: MAC_ADD, a: MacAW'(dy),
                         b: MacBW'(cfg.facing_sin)};
            state_in = S_L_PX;
         end
         S_L_PX: begin
            mac_req  = '{en: 1'b1, mode: MAC_BIAS, a: mac_acc[MacAW-1:0],
                         b: $signed({9'd0, cfg.pix_per_blk})};
            state_in = S_L_PXW;
         end
         // Keep x, start ry = dy*cos - dx*sin
         S_L_PXW: begin
            pix_x_in = to_coord(mac_acc, centre);
            mac_req  = '{en: 1'b1, mode: MAC_LOAD, a: MacAW'(dy),
                         b: MacBW'(cfg.facing_cos)};
            state_in = S_L_RY1;
         end
         S_L_RY1: begin
            mac_req  = '{en: 1'b1, mode: MAC_SUB, a: MacAW'(dx),
                         b: MacBW'(cfg.facing_sin)};
            state_in = S_L_PY;
         end
         S_L_PY: begin
            mac_req  = '{en: 1'b1, mode: MAC_BIAS, a: mac_acc[MacAW-1:0],
                         b: $signed({9'd0, cfg.pix_per_blk})};
            state_in = S_L_WR;
         end
         // Append the blip
         S_L_WR: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + CntW'(1);
            state_in  = S_IDLE;
         end
         // Walk the table, one blip at a time
         S_R_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = S_R_DX;
         end
         S_R_DX: begin
            mac_req  = '{en: 1'b1, mode: MAC_LOAD, a: MacAW'(ddx), b: MacBW'(ddx)};
            state_in = S_R_DY;
         end
         S_R_DY: begin
            mac_req  = '{en: 1'b1, mode: MAC_ADD, a: MacAW'(ddy), b: MacBW'(ddy)};
            state_in = S_R_TEST;
         end
         S_R_TEST: begin
            if (in_radius) begin
               mac_req  = '{en: 1'b1, mode: MAC_LOAD, a: mac_acc[MacAW-1:0],
                            b: $signed({1'b0, cfg.inv_radius_sq})};
               state_in = S_R_TERM;
            end else begin
               walk_in  = walk_nx;
               state_in = (walk_nx == count_ff) ? S_R_OUT : S_R_FETCH;
            end
         end
         S_R_TERM: begin
            sum_in   = (sum_wide > {1'b0, OneQ16}) ? OneQ16 : sum_wide[16:0];
            walk_in  = walk_nx;
            state_in = (walk_nx == count_ff) ? S_R_OUT : S_R_FETCH;
         end
         // Hand the word to the output register once it is free
         S_R_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               alpha_in     = scaled[23:16];
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      walk_ff  <= walk_in;
      sum_ff   <= sum_in;
      pix_x_ff <= pix_x_in;
      alpha_ff <= alpha_in;
      if (accept) begin
         col_ff <= req_tdata[7:0];
         row_ff <= req_tdata[15:8];
         px_ff  <= req_tdata[26:17];
         py_ff  <= req_tdata[36:27];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = alpha_ff;

endmodule

/* hdl/radar_blip_alpha_renderer_core.sv */
// Top level of the radar blip renderer: configuration registers and the
// sequencer, shared multiply unit and blip table. Depends on rbar_pkg,
// rbar_mac, rbar_blip_ram and rbar_seq.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_tvalid/tready    req_tdata (target/pixel), req_tuser (op)
//   rsp      out  rsp_tvalid/tready    rsp_tdata (alpha)
//   csr      in   csr_we               csr_index, csr_wdata
//
// Clears and done or table-full loads leave the sequencer idle; out-of-range loads stop after the range test.
// A render visits every stored blip in turn, and all of this work is
// bound by the single shared multiplier that serves every product in turn.
// req_tready is high only while the sequencer is idle; a waiting result word
// holds in the output register and only a following render waits for it.
// Reset (synchronous) empties the table and restores the register defaults.
`timescale 1ns / 1ps

module radar_blip_alpha_renderer_core
   import rbar_pkg::*;
#(
   parameter int MAX_BLIPS = 64
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // [7:0] target_col, [15:8] target_row, [16] target_done,
   // [26:17] pixel_x, [36:27] pixel_y, [39:37] zero
   input  logic [ReqDataW-1:0] req_tdata,
   // [1:0] op
   input  logic [ReqUserW-1:0] req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // [7:0] alpha
   output logic [RspDataW-1:0] rsp_tdata,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata
);

   localparam int CntW = $clog2(MAX_BLIPS + 1);
   localparam int IdxW = (MAX_BLIPS > 1) ? $clog2(MAX_BLIPS) : 1;

   cfg_type                cfg_ff, cfg_in;
   mac_req_type            mac_req;
   logic signed [AccW-1:0] mac_acc;
   logic                   ram_wr_en;
   logic [IdxW-1:0]        ram_wr_addr;
   logic [EntryW-1:0]      ram_wr_data;
   logic                   ram_rd_en;
   logic [IdxW-1:0]        ram_rd_addr;
   logic [EntryW-1:0]      ram_rd_data;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAP_SIZE:    cfg_in.map_size      = csr_wdata[10:0];
            CSR_PLAYER_X:    cfg_in.player_x      = csr_wdata[15:0];
            CSR_PLAYER_Y:    cfg_in.player_y      = csr_wdata[15:0];
            CSR_FACING_COS:  cfg_in.facing_cos    = $signed(csr_wdata[15:0]);
            CSR_FACING_SIN:  cfg_in.facing_sin    = $signed(csr_wdata[15:0]);
            CSR_PIX_PER_BLK: cfg_in.pix_per_blk   = csr_wdata[15:0];
            CSR_RADIUS_SQ:   cfg_in.radius_sq     = csr_wdata[17:0];
            CSR_INV_RAD_SQ:  cfg_in.inv_radius_sq = csr_wdata[23:0];
            default: ;
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_size      <= 11'd256;
         cfg_ff.player_x      <= 16'd0;
         cfg_ff.player_y      <= 16'd0;
         cfg_ff.facing_cos    <= 16'sd16384;
         cfg_ff.facing_sin    <= 16'sd0;
         cfg_ff.pix_per_blk   <= 16'd2592;
         cfg_ff.radius_sq     <= 18'd6710;
         cfg_ff.inv_radius_sq <= 24'd2500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbar_seq #(
      .MaxBlips (MAX_BLIPS),
      .CntW     (CntW),
      .IdxW     (IdxW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mac_req     (mac_req),
      .mac_acc     (mac_acc),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   rbar_mac u_mac (
      .clock   (clock),
      .mac_req (mac_req),
      .acc     (mac_acc)
   );

   rbar_blip_ram #(
      .Depth (MAX_BLIPS),
      .AddrW (IdxW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* hdl/rbar_checker.sv */
// Port-level checks of the radar blip renderer, bound to the top level.
// Depends on rbar_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rbar_checker
   import rbar_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [ReqUserW-1:0] req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RspDataW-1:0] rsp_tdata
);

   logic req_acc;
   logic rsp_stall;
   logic render_acc;
   logic other_acc;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign render_acc = req_acc && (req_tuser == OP_RENDER);
   assign other_acc  = req_acc && (req_tuser != OP_RENDER);

   // Keep a stalled result word on the bus
   `RBAR_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_stall, rsp_tvalid, "rsp word dropped")
   `RBAR_ASSERT_HOLD(a_rsp_data_holds, clock, reset, rsp_stall, rsp_tdata, "rsp word changed")

   // A render word keeps the block busy in the cycle after it is taken
   `RBAR_ASSERT_NEXT(a_render_busy, clock, reset, render_acc, !req_tready, "ready after render")

   // Only render words produce results
   `RBAR_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, other_acc, !$rose(rsp_tvalid), "stray rsp")

endmodule

bind radar_blip_alpha_renderer_core rbar_checker u_rbar_checker (.*);

/* tb/tb_radar_blip_alpha_renderer_core.sv */
// Self-checking testbench for radar_blip_alpha_renderer_core: a directed table, then
// randomized clear/load/render words under several register settings and idling mixes.
// Depends on rbar_pkg and the core RTL; the alpha predictor lives in this file.
`timescale 1ns / 1ps

module tb_radar_blip_alpha_renderer_core;
   import rbar_pkg::*;

   localparam int BLIP_DEPTH = 64;
   localparam logic [ReqUserW-1:0] OP_UNUSED = 2'd3;
   localparam int PROBE_ROWS = 24;
   localparam int ONE_Q16 = 65536;

   // One row of the directed table; pinned rows carry an alpha known by inspection
   typedef struct packed {
      logic [ReqUserW-1:0] op;
      logic [7:0]          col;
      logic [7:0]          row;
      logic                done;
      logic [9:0]          px;
      logic [9:0]          py;
      logic                pinned;
      logic [7:0]          alpha;
   } probe_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [ReqUserW-1:0] req_tuser = OP_CLEAR;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_MAP_SIZE;
   logic [CsrDataW-1:0] csr_wdata = '0;

   // Predictor state: register shadow and blip table
   cfg_type                  cfg_model;
   logic signed [CoordW-1:0] blip_x_tab [BLIP_DEPTH];
   logic signed [CoordW-1:0] blip_y_tab [BLIP_DEPTH];
   int                       blip_total;

   logic [7:0] alpha_expected_q [$];
   logic [7:0] alpha_want;

   int mismatch_count = 0;
   int alphas_checked = 0;
   int words_sent = 0;
   int render_words = 0;
   int load_words = 0;
   int clear_words = 0;
   int ignored_words = 0;
   int loads_stored = 0;
   int loads_dropped_full = 0;
   int settings_used = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   probe_row_type probe_table [PROBE_ROWS] = '{
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd0,    10'd0,    1'b1, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd1023, 10'd1023, 1'b1, 8'd0},
      '{OP_CLEAR,  8'd0,   8'd0,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_LOAD,   8'd0,   8'd0,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd132,  10'd132,  1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd133,  10'd132,  1'b0, 8'd0},
      '{OP_LOAD,   8'd0,   8'd0,   1'b1, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_LOAD,   8'd255, 8'd255, 1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_LOAD,   8'd11,  8'd0,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_LOAD,   8'd10,  8'd0,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_LOAD,   8'd0,   8'd10,  1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd234,  10'd133,  1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd133,  10'd234,  1'b0, 8'd0},
      '{OP_UNUSED, 8'd255, 8'd255, 1'b1, 10'd1023, 10'd1023, 1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd1023, 10'd0,    1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd0,    10'd1023, 1'b0, 8'd0},
      '{OP_LOAD,   8'd0,   8'd255, 1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_LOAD,   8'd255, 8'd0,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd133,  10'd133,  1'b0, 8'd0},
      '{OP_CLEAR,  8'd0,   8'd0,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd132,  10'd132,  1'b1, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd234,  10'd133,  1'b1, 8'd0},
      '{OP_LOAD,   8'd1,   8'd1,   1'b0, 10'd0,    10'd0,    1'b0, 8'd0},
      '{OP_RENDER, 8'd0,   8'd0,   1'b0, 10'd141,  10'd141,  1'b0, 8'd0}
   };

   radar_blip_alpha_renderer_core #(
      .MAX_BLIPS (BLIP_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_int(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void reset_model();
      cfg_model.map_size      = 11'd256;
      cfg_model.player_x      = 16'd0;
      cfg_model.player_y      = 16'd0;
      cfg_model.facing_cos    = 16'sd16384;
      cfg_model.facing_sin    = 16'sd0;
      cfg_model.pix_per_blk   = 16'd2592;
      cfg_model.radius_sq     = 18'd6710;
      cfg_model.inv_radius_sq = 24'd2500;
      blip_total = 0;
   endfunction

   // Scale a Q.22 rotated offset to Q12.8 pixels, round half up, add centre, saturate
   function automatic logic signed [CoordW-1:0] rotate_to_pixel(input longint rot,
                                                              input longint ctr);
      longint scale;
      longint v;
      scale = cfg_model.pix_per_blk;
      v = ((rot * scale + 64'sd2097152) >>> 22) + ctr;
      if (v > 64'sd524287) v = 64'sd524287;
      if (v < -64'sd524288) v = -64'sd524288;
      return v[CoordW-1:0];
   endfunction

   // Append one target cell to the blip table unless done, full or out of range
   function automatic void store_target(input logic [7:0] col, input logic [7:0] row,
                                        input logic done);
      longint dx, dy, c, s, ms, ctr, plx, ply;
      if (done) return;
      if (blip_total >= BLIP_DEPTH) begin
         loads_dropped_full++;
         return;
      end
      plx = cfg_model.player_x;
      ply = cfg_model.player_y;
      dx = {col, 8'h80};
      dy = {row, 8'h80};
      dx = dx - plx;
      dy = dy - ply;
      if (dx * dx + dy * dy > 64'sd8659204) return;
      c = $signed(cfg_model.facing_cos);
      s = $signed(cfg_model.facing_sin);
      ms = cfg_model.map_size;
      ctr = (ms - 1) * 128;
      blip_x_tab[blip_total] = rotate_to_pixel(dx * c + dy * s, ctr);
      blip_y_tab[blip_total] = rotate_to_pixel(dy * c - dx * s, ctr);
      blip_total++;
      loads_stored++;
   endfunction

   // Sum the falloff of every blip strictly inside the radius, saturate at one
   function automatic logic [7:0] render_alpha(input logic [9:0] px, input logic [9:0] py);
      longint sum, lim, inv, pxv, pyv, bx, by, ddx, ddy, d2, frac, scaled;
      sum = 0;
      lim = cfg_model.radius_sq;
      lim = lim << 8;
      inv = cfg_model.inv_radius_sq;
      pxv = px;
      pyv = py;
      pxv = pxv << 8;
      pyv = pyv << 8;
      for (int i = 0; i < blip_total; i++) begin
         bx = blip_x_tab[i];
         by = blip_y_tab[i];
         ddx = pxv - bx;
         ddy = pyv - by;
         d2 = ddx * ddx + ddy * ddy;
         if (d2 < lim) begin
            frac = (d2 * inv) >>> 16;
            if (frac > ONE_Q16) frac = ONE_Q16;
            sum = sum + ONE_Q16 - frac;
            if (sum > ONE_Q16) sum = ONE_Q16;
         end
      end
      scaled = (sum * 255) >>> 16;
      return scaled[7:0];
   endfunction

   // Write one register while the block is idle and mirror it in the shadow
   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [CsrDataW-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MAP_SIZE:    cfg_model.map_size      = value[10:0];
         CSR_PLAYER_X:    cfg_model.player_x      = value[15:0];
         CSR_PLAYER_Y:    cfg_model.player_y      = value[15:0];
         CSR_FACING_COS:  cfg_model.facing_cos    = value[15:0];
         CSR_FACING_SIN:  cfg_model.facing_sin    = value[15:0];
         CSR_PIX_PER_BLK: cfg_model.pix_per_blk   = value[15:0];
         CSR_RADIUS_SQ:   cfg_model.radius_sq     = value[17:0];
         CSR_INV_RAD_SQ:  cfg_model.inv_radius_sq = value[23:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Present one word, hold it until accepted, then update the predictor.
   // Entered and left at a falling edge; valid stays high for a following word.
   task automatic send_word(input logic [ReqUserW-1:0] op, input logic [7:0] col,
                            input logic [7:0] row, input logic done,
                            input logic [9:0] px, input logic [9:0] py,
                            input logic pinned, input logic [7:0] pinned_alpha);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, py, px, done, row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      case (op)
         OP_CLEAR: begin
            blip_total = 0;
            clear_words++;
         end
         OP_LOAD: begin
            store_target(col, row, done);
            load_words++;
         end
         OP_RENDER: begin
            alpha_expected_q.push_back(pinned ? pinned_alpha : render_alpha(px, py));
            render_words++;
         end
         default: ignored_words++;
      endcase
      @(negedge clock);
   endtask

   // Wait for every expected word, then give a trailing load time to finish
   task automatic settle(input int tail);
      while (alpha_expected_q.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   // Pick a register setting for one phase; some phases hold the extremes
   task automatic program_phase(input int k);
      int unsigned msize, plx, ply, ppb, rad, rsq, inv;
      int ci, si;
      real ang;
      msize = 32 << $urandom_range(0, 5);
      plx = $urandom_range(0, 65535);
      ply = $urandom_range(0, 65535);
      ang = $urandom_range(0, 359) * 3.14159265 / 180.0;
      ci = $rtoi(16384.0 * $cos(ang));
      si = $rtoi(16384.0 * $sin(ang));
      rad = $urandom_range(2, 31);
      rsq = rad * rad * 256;
      inv = (1 << 24) / rsq;
      case (k)
         1: msize = 1024;
         2: msize = 8;
         3: begin
            msize = 1024;
            plx = 65535;
            ply = 65535;
            ci = -16384;
            si = 16384;
            rsq = 262143;
            inv = 24'hFFFFFF;
         end
         4: begin
            rsq = $urandom_range(0, 262143);
            inv = $urandom_range(0, 24'hFFFFFF);
         end
         5: begin
            msize = 0;
            plx = 0;
            ply = 0;
            ci = 0;
            si = -16384;
         end
         6: begin
            msize = 8;
            rsq = 0;
            inv = 0;
         end
         default: ;
      endcase
      ppb = (msize == 0) ? 2594 : (msize * 152) / 15;
      if (k == 3) ppb = 65535;
      if (k == 6) ppb = 0;
      write_reg(CSR_MAP_SIZE, CsrDataW'(msize));
      write_reg(CSR_PLAYER_X, CsrDataW'(plx));
      write_reg(CSR_PLAYER_Y, CsrDataW'(ply));
      write_reg(CSR_FACING_COS, {8'h00, ci[15:0]});
      write_reg(CSR_FACING_SIN, {8'h00, si[15:0]});
      write_reg(CSR_PIX_PER_BLK, CsrDataW'(ppb));
      write_reg(CSR_RADIUS_SQ, CsrDataW'(rsq));
      write_reg(CSR_INV_RAD_SQ, CsrDataW'(inv));
      settings_used++;
   endtask

   function automatic logic [7:0] near_cell(input logic [7:0] base, input int span);
      int v;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
      v = clamp_int(v, 0, 255);
      return v[7:0];
   endfunction

   function automatic logic [9:0] near_pixel(input logic signed [CoordW-1:0] coord);
      int v;
      v = coord;
      v = (v >>> 8) + int'($urandom_range(0, 24)) - 12;
      v = clamp_int(v, 0, 1023);
      return v[9:0];
   endfunction

   // Empty the table, then load more in-range cells than it can hold
   task automatic fill_table();
      send_word(OP_CLEAR, 8'd0, 8'd0, 1'b0, 10'd0, 10'd0, 1'b0, 8'd0);
      repeat (BLIP_DEPTH + 6)
         send_word(OP_LOAD, near_cell(cfg_model.player_x[15:8], 6),
                   near_cell(cfg_model.player_y[15:8], 6), 1'b0,
                   10'd0, 10'd0, 1'b0, 8'd0);
   endtask

   // Mostly loads near the player and renders near stored blips, some noise
   task automatic random_word();
      int r, pick;
      logic [7:0] col, row;
      logic [9:0] px, py;
      logic done;
      r = $urandom_range(0, 99);
      col = 8'($urandom);
      row = 8'($urandom);
      done = 1'($urandom);
      px = 10'($urandom);
      py = 10'($urandom);
      if (r < 4) begin
         send_word(OP_CLEAR, col, row, done, px, py, 1'b0, 8'd0);
      end else if (r < 7) begin
         send_word(OP_UNUSED, col, row, done, px, py, 1'b0, 8'd0);
      end else if (r < 42) begin
         col = near_cell(cfg_model.player_x[15:8], 12);
         row = near_cell(cfg_model.player_y[15:8], 12);
         done = ($urandom_range(0, 7) == 0);
         send_word(OP_LOAD, col, row, done, px, py, 1'b0, 8'd0);
      end else if (r < 50) begin
         send_word(OP_LOAD, col, row, done, px, py, 1'b0, 8'd0);
      end else begin
         if (blip_total > 0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, blip_total - 1);
            px = near_pixel(blip_x_tab[pick]);
            py = near_pixel(blip_y_tab[pick]);
         end
         send_word(OP_RENDER, col, row, done, px, py, 1'b0, 8'd0);
      end
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 56; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 56; end
         default: begin send_idle_pct = 35; rsp_stall_pct = 35; end
      endcase
   endtask

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // Compare each accepted alpha word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (alpha_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: alpha word %0d arrived with none expected", $time, rsp_tdata);
         end else begin
            alpha_want = alpha_expected_q.pop_front();
            alphas_checked++;
            if (rsp_tdata !== alpha_want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: alpha expected %0d, got %0d", $time, alpha_want, rsp_tdata);
            end
         end
      end
   end

   initial begin
      reset_model();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table under the reset register values
      set_idling(0);
      for (int i = 0; i < PROBE_ROWS; i++)
         send_word(probe_table[i].op, probe_table[i].col, probe_table[i].row,
                   probe_table[i].done, probe_table[i].px, probe_table[i].py,
                   probe_table[i].pinned, probe_table[i].alpha);
      req_tvalid <= 1'b0;

      // Random phases, each with its own register setting and idling mix
      for (int phase = 0; phase < 8; phase++) begin
         settle(16);
         program_phase(phase);
         set_idling(phase % 4);
         if (phase % 3 == 0) fill_table();
         repeat (80) random_word();
         req_tvalid <= 1'b0;
      end

      settle(400);
      $display("Sent %0d words: %0d renders, %0d loads, %0d clears, %0d unknown ops.",
               words_sent, render_words, load_words, clear_words, ignored_words);
      $display("%0d alphas checked; %0d blips stored, %0d loads dropped on a full table, "
               , alphas_checked, loads_stored, loads_dropped_full,
               "%0d register settings.", settings_used);
      if (mismatch_count == 0 && alpha_expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #(15_000_000);
      $display("Timeout: %0d alpha words still pending", alpha_expected_q.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
